/* sv/rtw_pkg.sv */
// rtw_pkg: shared types and constants for the retransmit timer window
// holds payload structs, result and command codes, and the cell control struct
// no dependencies
package rtw_pkg;

  localparam int TAG_W   = 8;
  localparam int DELAY_W = 8;
  localparam int CNT_W   = 9;
  localparam int RCNT_W  = 5;
  localparam int LIMIT_W = 4;
  localparam int GEN_W   = 5;

  localparam logic [RCNT_W-1:0]  RCNT_MAX          = 5'd31;
  localparam logic [GEN_W-1:0]   MAX_RESULTS       = 5'd16;
  localparam logic [LIMIT_W-1:0] RESEND_LIMIT_RST  = 4'd5;
  localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST  = 4'd6;

  // input command codes
  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_ADD_OK = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_RESEND = 2'd2,
    KIND_FAIL   = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic {
    CFG_RESEND_LIMIT = 1'b0,
    CFG_WINDOW_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [TAG_W-1:0]   frame_tag;
    logic [DELAY_W-1:0] resend_delay;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [TAG_W-1:0] result_tag;
    logic             last;
  } out_item_t;

  // one pending frame as held in a cell
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [DELAY_W-1:0] delay;
    logic [CNT_W-1:0]   tick_cnt;
    logic [RCNT_W-1:0]  rcnt;
  } entry_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_DROP,
    OP_POP_KEEP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   push;
  } cell_ctl_t;

endpackage

/* sv/rtw_cell.sv */
// rtw_cell: one slot of the pending frame chain
// shifts toward the tail on insert, toward the head on pop; depends on rtw_pkg
module rtw_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rtw_pkg::cell_ctl_t ctl,
  input  logic              left_vld,
  input  rtw_pkg::entry_t   left_ent,
  input  logic              right_vld,
  input  rtw_pkg::entry_t   right_ent,
  output logic              vld,
  output rtw_pkg::entry_t   ent
);
  import rtw_pkg::*;

  logic   vld_r, vld_nxt;
  entry_t ent_r, ent_nxt;

  // next slot contents; on a keeping pop the tail cell takes the updated head
  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    unique case (ctl.op)
      OP_HOLD: begin
        vld_nxt = vld_r;
      end
      OP_INSERT: begin
        vld_nxt = left_vld;
        ent_nxt = left_ent;
      end
      OP_POP_DROP: begin
        vld_nxt = right_vld;
        ent_nxt = right_ent;
      end
      OP_POP_KEEP: begin
        if (vld_r && !right_vld) begin
          vld_nxt = 1'b1;
          ent_nxt = ctl.push;
        end else begin
          vld_nxt = right_vld;
          ent_nxt = right_ent;
        end
      end
      default: begin
        vld_nxt = vld_r;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign vld = vld_r;
  assign ent = ent_r;

endmodule

/* sv/retransmit_timer_window_core.sv */
// retransmit_timer_window_core: top level of the retransmit timer window
// a chain of rtw_cell slots plus the head sequencer; depends on rtw_pkg, rtw_cell
//
// Usage
//   in_item is taken when start is high and busy is low. An add (cmd 0) puts
//   the frame at the head of the chain and gives one result (ok or full) on
//   the next cycle; busy stays low, so an item can follow at once.
//   A tick (cmd 1) raises busy and rotates the chain once through cell 0:
//   each cycle the head entry is updated and either goes back in at the tail
//   or is dropped. An entry that is both resent and failed first gives its resend
//   result and is then dropped with a fail result.
//   Results leave at most one per cycle through a one-deep hold register so that the
//   final one of a tick carries last; out_valid marks each for one cycle and
//   the receiver cannot stall. At most 16 results per tick are given.
//   cfg transfers write resend_limit (index 0) and window_limit (index 1);
//   cfg_ready is always high and writes are meant for idle periods.
//   Reset empties the window and loads resend_limit 5, window_limit 6.
module retransmit_timer_window_core #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rtw_pkg::in_item_t   in_item,
  output logic                out_valid,
  output rtw_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  rtw_pkg::cfg_idx_t   cfg_index,
  input  logic [3:0]          cfg_data
);
  import rtw_pkg::*;

  localparam int OW = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = (OW > LIMIT_W) ? OW : LIMIT_W;

  // chain wiring: index 0 feeds cell 0 from the left, cell i drives index i+1
  logic      c_vld [0:WINDOW_DEPTH+1];
  entry_t    c_ent [0:WINDOW_DEPTH+1];
  cell_ctl_t ctl;
  entry_t    new_ent;

  assign new_ent = '{tag: in_item.frame_tag, delay: in_item.resend_delay,
                     tick_cnt: '0, rcnt: '0};
  assign c_vld[0] = 1'b1;
  assign c_ent[0] = new_ent;
  assign c_vld[WINDOW_DEPTH+1] = 1'b0;
  assign c_ent[WINDOW_DEPTH+1] = '0;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    rtw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_vld  (c_vld[i]),
      .left_ent  (c_ent[i]),
      .right_vld (c_vld[i+2]),
      .right_ent (c_ent[i+2]),
      .vld       (c_vld[i+1]),
      .ent       (c_ent[i+1])
    );
  end

  // control and output registers
  logic [LIMIT_W-1:0] rlim_r, rlim_nxt;
  logic [LIMIT_W-1:0] wlim_r, wlim_nxt;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [OW-1:0]      steps_r, steps_nxt;
  logic               walk_r, walk_nxt;
  logic               pend_r, pend_nxt;
  logic [GEN_W-1:0]   gen_r, gen_nxt;
  logic               hold_vld_r, hold_vld_nxt;
  kind_t              hold_kind_r, hold_kind_nxt;
  logic [TAG_W-1:0]   hold_tag_r, hold_tag_nxt;
  logic               out_vld_r, out_vld_nxt;
  out_item_t          out_r, out_nxt;

  // head entry evaluation
  entry_t             head;
  logic               resend;
  logic               fail;
  logic [RCNT_W-1:0]  rc_new;
  logic [CNT_W-1:0]   cnt_new;

  assign head    = c_ent[1];
  assign resend  = head.tick_cnt > CNT_W'(head.delay);
  assign rc_new  = !resend ? head.rcnt :
                   (head.rcnt == RCNT_MAX) ? head.rcnt : head.rcnt + 1'b1;
  assign cnt_new = resend ? '0 : head.tick_cnt + 1'b1;
  assign fail    = rc_new > RCNT_W'(rlim_r);

  // window full check
  logic full;
  assign full = (CW'(occ_r) >= CW'(wlim_r)) || (occ_r >= OW'(WINDOW_DEPTH));

  logic    accept;
  logic    res_vld;
  kind_t   res_kind;

  assign accept = start && !walk_r;

  always_comb begin
    ctl           = '{op: OP_HOLD, push: '{tag: head.tag, delay: head.delay,
                                           tick_cnt: cnt_new, rcnt: rc_new}};
    rlim_nxt      = rlim_r;
    wlim_nxt      = wlim_r;
    occ_nxt       = occ_r;
    steps_nxt     = steps_r;
    walk_nxt      = walk_r;
    pend_nxt      = pend_r;
    gen_nxt       = gen_r;
    hold_vld_nxt  = hold_vld_r;
    hold_kind_nxt = hold_kind_r;
    hold_tag_nxt  = hold_tag_r;
    out_vld_nxt   = 1'b0;
    out_nxt       = out_r;
    res_vld       = 1'b0;
    res_kind      = KIND_RESEND;

    // configuration transfer
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESEND_LIMIT: rlim_nxt = cfg_data;
        CFG_WINDOW_LIMIT: wlim_nxt = cfg_data;
        default:          rlim_nxt = rlim_r;
      endcase
    end

    if (!walk_r) begin
      // idle: take a new command
      if (accept) begin
        if (in_item.cmd == CMD_ADD) begin
          out_vld_nxt = 1'b1;
          if (full) begin
            out_nxt = '{kind: KIND_FULL, result_tag: in_item.frame_tag, last: 1'b1};
          end else begin
            ctl.op  = OP_INSERT;
            occ_nxt = occ_r + 1'b1;
            out_nxt = '{kind: KIND_ADD_OK, result_tag: in_item.frame_tag, last: 1'b1};
          end
        end else begin
          walk_nxt     = 1'b1;
          steps_nxt    = occ_r;
          pend_nxt     = 1'b0;
          gen_nxt      = '0;
          hold_vld_nxt = 1'b0;
        end
      end
    end else if (steps_r == '0) begin
      // walk done: release the held result as the final one
      walk_nxt     = 1'b0;
      hold_vld_nxt = 1'b0;
      if (hold_vld_r) begin
        out_vld_nxt = 1'b1;
        out_nxt     = '{kind: hold_kind_r, result_tag: hold_tag_r, last: 1'b1};
      end
    end else begin
      // one step on the head entry
      priority if (pend_r) begin
        res_vld   = 1'b1;
        res_kind  = KIND_FAIL;
        ctl.op    = OP_POP_DROP;
        pend_nxt  = 1'b0;
        steps_nxt = steps_r - 1'b1;
        occ_nxt   = occ_r - 1'b1;
      end else if (resend && fail) begin
        res_vld  = 1'b1;
        res_kind = KIND_RESEND;
        pend_nxt = 1'b1;
      end else if (resend) begin
        res_vld   = 1'b1;
        res_kind  = KIND_RESEND;
        ctl.op    = OP_POP_KEEP;
        steps_nxt = steps_r - 1'b1;
      end else if (fail) begin
        res_vld   = 1'b1;
        res_kind  = KIND_FAIL;
        ctl.op    = OP_POP_DROP;
        steps_nxt = steps_r - 1'b1;
        occ_nxt   = occ_r - 1'b1;
      end else begin
        ctl.op    = OP_POP_KEEP;
        steps_nxt = steps_r - 1'b1;
      end

      // result goes to the hold register, the previous one goes out
      if (res_vld && (gen_r < MAX_RESULTS)) begin
        gen_nxt       = gen_r + 1'b1;
        hold_vld_nxt  = 1'b1;
        hold_kind_nxt = res_kind;
        hold_tag_nxt  = head.tag;
        if (hold_vld_r) begin
          out_vld_nxt = 1'b1;
          out_nxt     = '{kind: hold_kind_r, result_tag: hold_tag_r, last: 1'b0};
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rlim_r     <= RESEND_LIMIT_RST;
      wlim_r     <= WINDOW_LIMIT_RST;
      occ_r      <= '0;
      steps_r    <= '0;
      walk_r     <= 1'b0;
      pend_r     <= 1'b0;
      gen_r      <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      rlim_r     <= rlim_nxt;
      wlim_r     <= wlim_nxt;
      occ_r      <= occ_nxt;
      steps_r    <= steps_nxt;
      walk_r     <= walk_nxt;
      pend_r     <= pend_nxt;
      gen_r      <= gen_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    hold_kind_r <= hold_kind_nxt;
    hold_tag_r  <= hold_tag_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = walk_r;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

endmodule

/* sv/rtw_checker.sv */
// rtw_checker: port-level checks for retransmit_timer_window_core
// bound to the top level below; depends on rtw_pkg
module rtw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input rtw_pkg::in_item_t  in_item,
  input logic               out_valid,
  input rtw_pkg::out_item_t out_item
);
  import rtw_pkg::*;

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // an add gives exactly one final result, ok or full
  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.cmd == CMD_ADD |=>
      out_valid && out_item.last &&
      (out_item.kind == KIND_ADD_OK || out_item.kind == KIND_FULL))
    else $error("add transfer without a single final result");

  // a non-final result only comes while a tick is walking
  a_nonfinal_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final result outside a tick");

  // resend and fail results belong to a tick in progress or just ended
  a_tick_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_RESEND || out_item.kind == KIND_FAIL)
      |-> busy || $fell(busy))
    else $error("tick result outside a tick");

  // the end of a walk with a result marks it final
  a_walk_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && out_valid |-> out_item.last)
    else $error("tick ended without a final result");

endmodule

bind retransmit_timer_window_core rtw_checker u_rtw_checker (.*);
